/* rtl/tgm_pkg.sv */
// Shared constants and codes for the touch gesture to mouse translator.
package tgm_pkg;

  localparam int FINGER_SLOTS_DEF = 5;
  localparam int REPORTED_POINTS  = 5;

  localparam int COORD_W = 12;
  localparam int TIME_W  = 32;
  localparam int COUNT_W = 3;
  localparam int MLIM_W  = 13;
  localparam int TLIM_W  = 16;
  localparam int GAIN_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_MOVE_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_TIME_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_GAIN      = 2'd2;

  localparam logic [MLIM_W-1:0] TAP_MOVE_LIMIT_RST = 13'd20;
  localparam logic [TLIM_W-1:0] TAP_TIME_LIMIT_RST = 16'd200;
  localparam logic [GAIN_W-1:0] MOVE_GAIN_RST      = 16'd256;

  // Result action codes.
  localparam logic ACT_MOVE  = 1'b0;
  localparam logic ACT_CLICK = 1'b1;

  // Button codes.
  localparam logic [1:0] BTN_LEFT   = 2'd0;
  localparam logic [1:0] BTN_RIGHT  = 2'd1;
  localparam logic [1:0] BTN_MIDDLE = 2'd2;

  localparam logic signed [7:0] MOVE_MAX = 8'sd127;

  typedef logic [COORD_W-1:0] coord_t;

endpackage

/* rtl/touch_gesture_to_mouse.sv */
// Top level of the touch gesture to mouse translator.
// Each input beat is one touch-controller poll. A beat is captured in an input
// register; when the output register is free or being taken, a single pass of
// logic updates the per-finger session state and loads at most one result (a
// pointer move or a button click) into the output register. One poll is taken
// every cycle while the output is not stalled; the limit is the one registered
// pass that both updates the session state and fills the output register, so
// when the output register is full and not taken, in_ready drops once the
// input register is occupied too.
module touch_gesture_to_mouse
  import tgm_pkg::*;
#(
  parameter int FINGER_SLOTS = FINGER_SLOTS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [COUNT_W-1:0]      in_finger_count,
  input  logic [TIME_W-1:0]       in_now_ms,
  input  logic [COORD_W-1:0]      in_x0,
  input  logic [COORD_W-1:0]      in_y0,
  input  logic [COORD_W-1:0]      in_x1,
  input  logic [COORD_W-1:0]      in_y1,
  input  logic [COORD_W-1:0]      in_x2,
  input  logic [COORD_W-1:0]      in_y2,
  input  logic [COORD_W-1:0]      in_x3,
  input  logic [COORD_W-1:0]      in_y3,
  input  logic [COORD_W-1:0]      in_x4,
  input  logic [COORD_W-1:0]      in_y4,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_action,
  output logic signed [7:0]       out_move_x,
  output logic signed [7:0]       out_move_y,
  output logic [1:0]              out_button
);

  localparam int SLOTS = (FINGER_SLOTS < REPORTED_POINTS) ? FINGER_SLOTS : REPORTED_POINTS;
  localparam logic [COUNT_W-1:0] SLOTS_C = COUNT_W'(SLOTS);

  function automatic coord_t absdiff(input coord_t a, input coord_t b);
    return (a > b) ? coord_t'(a - b) : coord_t'(b - a);
  endfunction

  // Magnitude times Q8.8 gain, truncated, clamped to 127, then given the sign.
  function automatic logic [7:0] scale_delta(input coord_t a, input coord_t b,
                                             input logic [GAIN_W-1:0] g);
    logic [COORD_W+GAIN_W-1:0] prod;
    logic [6:0]                v;
    prod = (COORD_W+GAIN_W)'(absdiff(a, b)) * (COORD_W+GAIN_W)'(g);
    v    = (|prod[COORD_W+GAIN_W-1:15]) ? 7'(MOVE_MAX) : prod[14:8];
    return (a < b) ? (8'd0 - {1'b0, v}) : {1'b0, v};
  endfunction

  // Configuration registers.
  logic [MLIM_W-1:0] move_lim_r;
  logic [TLIM_W-1:0] time_lim_r;
  logic [GAIN_W-1:0] gain_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      move_lim_r <= TAP_MOVE_LIMIT_RST;
      time_lim_r <= TAP_TIME_LIMIT_RST;
      gain_r     <= MOVE_GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TAP_MOVE_LIMIT: move_lim_r <= cfg_data[MLIM_W-1:0];
        CFG_TAP_TIME_LIMIT: time_lim_r <= cfg_data;
        CFG_MOVE_GAIN:      gain_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  logic               s1_valid_r;
  logic [COUNT_W-1:0] cnt_raw_r;
  logic [TIME_W-1:0]  now_r;
  coord_t             px_r [REPORTED_POINTS];
  coord_t             py_r [REPORTED_POINTS];
  logic               adv;

  assign adv      = s1_valid_r && (!out_valid || out_ready);
  assign in_ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cnt_raw_r <= in_finger_count;
      now_r     <= in_now_ms;
      px_r[0]   <= in_x0;
      py_r[0]   <= in_y0;
      px_r[1]   <= in_x1;
      py_r[1]   <= in_y1;
      px_r[2]   <= in_x2;
      py_r[2]   <= in_y2;
      px_r[3]   <= in_x3;
      py_r[3]   <= in_y3;
      px_r[4]   <= in_x4;
      py_r[4]   <= in_y4;
    end
  end

  // Session state.
  coord_t             start_x_r [SLOTS];
  coord_t             start_y_r [SLOTS];
  coord_t             last_x_r  [SLOTS];
  coord_t             last_y_r  [SLOTS];
  logic [TIME_W-1:0]  start_t_r [SLOTS];
  logic [SLOTS-1:0]   active_r;
  logic               drag_r;
  logic [COUNT_W-1:0] prev_r;
  logic [COUNT_W-1:0] peak_r;

  coord_t             start_x_nxt [SLOTS];
  coord_t             start_y_nxt [SLOTS];
  coord_t             last_x_nxt  [SLOTS];
  coord_t             last_y_nxt  [SLOTS];
  logic [TIME_W-1:0]  start_t_nxt [SLOTS];
  logic [SLOTS-1:0]   active_nxt;
  logic               drag_nxt;
  logic [COUNT_W-1:0] peak_nxt;

  logic [COUNT_W-1:0] cnt;
  logic [SLOTS-1:0]   starting;
  logic               one_down;
  logic               release_all;
  logic               drag_eff;
  logic               drag_new;
  logic [MLIM_W-1:0]  travel;
  logic               move_hit;
  logic               tap_ok;
  logic [MLIM_W-1:0]  moved;
  logic [TIME_W-1:0]  held;

  always_comb begin
    cnt         = (cnt_raw_r > SLOTS_C) ? SLOTS_C : cnt_raw_r;
    release_all = (prev_r != '0) && (cnt == '0);

    // Slots from the previous count up to the new count begin a fresh touch.
    for (int i = 0; i < SLOTS; i++) begin
      starting[i]    = (COUNT_W'(i) >= prev_r) && (COUNT_W'(i) < cnt);
      start_x_nxt[i] = starting[i] ? px_r[i] : start_x_r[i];
      start_y_nxt[i] = starting[i] ? py_r[i] : start_y_r[i];
      last_x_nxt[i]  = starting[i] ? px_r[i] : last_x_r[i];
      last_y_nxt[i]  = starting[i] ? py_r[i] : last_y_r[i];
      start_t_nxt[i] = starting[i] ? now_r   : start_t_r[i];
      active_nxt[i]  = starting[i] | active_r[i];
    end
    peak_nxt = (cnt > peak_r) ? cnt : peak_r;
    drag_eff = starting[0] ? 1'b0 : drag_r;

    // Single-finger tracking works on the slot 0 values after any restart.
    one_down = (cnt == COUNT_W'(1)) && active_nxt[0];
    travel   = MLIM_W'(absdiff(px_r[0], start_x_nxt[0])) +
               MLIM_W'(absdiff(py_r[0], start_y_nxt[0]));
    drag_new = drag_eff || (travel > move_lim_r);
    move_hit = one_down && drag_new &&
               ((px_r[0] != last_x_nxt[0]) || (py_r[0] != last_y_nxt[0]));
    drag_nxt = one_down ? drag_new : drag_eff;
    if (one_down) begin
      last_x_nxt[0] = px_r[0];
      last_y_nxt[0] = py_r[0];
    end

    // Tap check across every slot that took part in the session.
    tap_ok = 1'b1;
    for (int i = 0; i < SLOTS; i++) begin
      moved = MLIM_W'(absdiff(last_x_r[i], start_x_r[i])) +
              MLIM_W'(absdiff(last_y_r[i], start_y_r[i]));
      held  = now_r - start_t_r[i];
      if ((COUNT_W'(i) < peak_r) &&
          ((moved > move_lim_r) || (held > TIME_W'(time_lim_r)))) begin
        tap_ok = 1'b0;
      end
    end

    if (release_all) begin
      for (int i = 0; i < SLOTS; i++) begin
        start_x_nxt[i] = '0;
        start_y_nxt[i] = '0;
        last_x_nxt[i]  = '0;
        last_y_nxt[i]  = '0;
        start_t_nxt[i] = '0;
      end
      active_nxt = '0;
      drag_nxt   = 1'b0;
      peak_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        start_x_r[i] <= '0;
        start_y_r[i] <= '0;
        last_x_r[i]  <= '0;
        last_y_r[i]  <= '0;
        start_t_r[i] <= '0;
      end
      active_r <= '0;
      drag_r   <= 1'b0;
      prev_r   <= '0;
      peak_r   <= '0;
    end else if (adv) begin
      for (int i = 0; i < SLOTS; i++) begin
        start_x_r[i] <= start_x_nxt[i];
        start_y_r[i] <= start_y_nxt[i];
        last_x_r[i]  <= last_x_nxt[i];
        last_y_r[i]  <= last_y_nxt[i];
        start_t_r[i] <= start_t_nxt[i];
      end
      active_r <= active_nxt;
      drag_r   <= drag_nxt;
      prev_r   <= cnt;
      peak_r   <= peak_nxt;
    end
  end

  // Result register.
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              emit;
  logic              act_nxt;
  logic signed [7:0] mx_nxt;
  logic signed [7:0] my_nxt;
  logic [1:0]        btn_nxt;
  logic              act_r;
  logic signed [7:0] mx_r;
  logic signed [7:0] my_r;
  logic [1:0]        btn_r;

  always_comb begin
    emit    = move_hit || (release_all && tap_ok);
    act_nxt = ACT_MOVE;
    mx_nxt  = '0;
    my_nxt  = '0;
    btn_nxt = BTN_LEFT;
    if (release_all) begin
      act_nxt = ACT_CLICK;
      case (peak_r)
        COUNT_W'(1): btn_nxt = BTN_LEFT;
        COUNT_W'(2): btn_nxt = BTN_RIGHT;
        default:     btn_nxt = BTN_MIDDLE;
      endcase
    end else begin
      mx_nxt = scale_delta(px_r[0], last_x_r[0], gain_r);
      my_nxt = scale_delta(py_r[0], last_y_r[0], gain_r);
    end
    out_valid_nxt = adv ? emit : (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      act_r <= act_nxt;
      mx_r  <= mx_nxt;
      my_r  <= my_nxt;
      btn_r <= btn_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_action = act_r;
  assign out_move_x = mx_r;
  assign out_move_y = my_r;
  assign out_button = btn_r;

endmodule

/* rtl/tgm_checker.sv */
// Port-level checks for the touch gesture to mouse translator, bound to the top level.
module tgm_checker
  import tgm_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_action,
  input logic signed [7:0] out_move_x,
  input logic signed [7:0] out_move_y,
  input logic [1:0]        out_button
);

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_action) &&
      $stable(out_move_x) && $stable(out_move_y) && $stable(out_button))
    else $error("result beat changed while stalled");

  // A click carries no motion and a defined button.
  a_click_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == ACT_CLICK |->
      out_move_x == 8'sd0 && out_move_y == 8'sd0 &&
      (out_button == BTN_LEFT || out_button == BTN_RIGHT || out_button == BTN_MIDDLE))
    else $error("malformed click");

  // A move stays inside the clamp and carries the left button code.
  a_move_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == ACT_MOVE |->
      out_button == BTN_LEFT && out_move_x != -8'sd128 && out_move_y != -8'sd128)
    else $error("malformed move");

  // Nothing is offered in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind touch_gesture_to_mouse tgm_checker u_tgm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_action (out_action),
  .out_move_x (out_move_x),
  .out_move_y (out_move_y),
  .out_button (out_button)
);
